// ===== src/swqt_pkg.sv =====
// Package: status codes, commands and sequencer states for the wait-queue table.
package swqt_pkg;

    localparam int NPROC = 32;
    localparam int PW    = 5;

    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DESC,
        S_WALK,
        S_OUT
    } state_t;

endpackage

// ===== src/semaphore_wait_queue_table.sv =====
// Top level of the semaphore wait-queue table.
// One item is taken at a time. Commands that name a key step one shared key
// comparator through the descriptor pool, one descriptor a cycle, stopping at
// the last descriptor or earlier when the key is found, then go on to the
// descriptor step and the result load. Remove-given-process skips the search
// and, when the process is not at the head, walks the process's queue one link
// a cycle. A result waits in an output register; the next item is taken once
// that register is free.
// No clearing pass: in-use and waiting flags reset at once.
module semaphore_wait_queue_table
    import swqt_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], sem_key[33:2], proc_id[38:34], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], proc_out[6:2], released[7]
    output logic [7:0]  m_tdata
);
    localparam int DW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);

    logic [31:0]       key_mem  [NUM_ENTRIES];
    logic [PW-1:0]     head_mem [NUM_ENTRIES];
    logic [PW-1:0]     tail_mem [NUM_ENTRIES];
    logic [PW-1:0]     next_mem [NPROC];
    logic [DW-1:0]     pdesc_mem[NPROC];
    logic [NUM_ENTRIES-1:0] in_use_reg;
    logic [NPROC-1:0]  waiting_reg;

    state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [31:0] key_reg;
    logic [PW-1:0] pid_reg, q_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] d_reg, free_reg;
    logic        found_reg, free_ok_reg;
    logic [1:0]  st_reg;
    logic [PW-1:0] pout_reg;
    logic        rel_reg, mvalid_reg;

    logic [DW-1:0] cidx;
    logic          last_cnt, hit;

    assign cidx     = cnt_reg[DW-1:0];
    assign last_cnt = (cnt_reg == CW'(NUM_ENTRIES - 1));
    assign hit      = in_use_reg[cidx] && (key_mem[cidx] == key_reg);

    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {rel_reg, pout_reg, st_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = (cmd_t'(s_tdata[1:0]) == CMD_REMOVE) ? S_DESC : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit || last_cnt) state_next = S_DESC;
            end
            S_DESC: begin
                if (cmd_reg == CMD_REMOVE && waiting_reg[pid_reg]
                    && head_mem[pdesc_mem[pid_reg]] != pid_reg) begin
                    state_next = S_WALK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_WALK: begin
                if (next_mem[q_reg] == pid_reg) state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            waiting_reg <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mvalid_reg && m_tready) mvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg     <= cmd_t'(s_tdata[1:0]);
                        key_reg     <= s_tdata[33:2];
                        pid_reg     <= s_tdata[38:34];
                        cnt_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        st_reg      <= ST_OK;
                        pout_reg    <= '0;
                        rel_reg     <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    // take the lowest free descriptor on the way
                    if (!in_use_reg[cidx] && !free_ok_reg) begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= cidx;
                    end
                    if (hit) begin
                        found_reg <= 1'b1;
                        d_reg     <= cidx;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DESC: begin
                    case (cmd_reg)
                        CMD_BLOCK: begin
                            if (waiting_reg[pid_reg]) begin
                                st_reg <= ST_ABSENT;
                            end else if (found_reg) begin
                                next_mem[tail_mem[d_reg]] <= pid_reg;
                                tail_mem[d_reg]    <= pid_reg;
                                next_mem[pid_reg]  <= pid_reg;
                                waiting_reg[pid_reg] <= 1'b1;
                                pdesc_mem[pid_reg] <= d_reg;
                            end else if (free_ok_reg) begin
                                in_use_reg[free_reg] <= 1'b1;
                                key_mem[free_reg]  <= key_reg;
                                head_mem[free_reg] <= pid_reg;
                                tail_mem[free_reg] <= pid_reg;
                                next_mem[pid_reg]  <= pid_reg;
                                waiting_reg[pid_reg] <= 1'b1;
                                pdesc_mem[pid_reg] <= free_reg;
                            end else begin
                                st_reg <= ST_FULL;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (!found_reg) begin
                                st_reg <= ST_ABSENT;
                            end else begin
                                pout_reg <= head_mem[d_reg];
                                if (cmd_reg == CMD_POP) begin
                                    waiting_reg[head_mem[d_reg]] <= 1'b0;
                                    if (head_mem[d_reg] == tail_mem[d_reg]) begin
                                        in_use_reg[d_reg] <= 1'b0;
                                        rel_reg <= 1'b1;
                                    end else begin
                                        head_mem[d_reg] <= next_mem[head_mem[d_reg]];
                                    end
                                end
                            end
                        end
                        default: begin
                            d_reg <= pdesc_mem[pid_reg];
                            q_reg <= head_mem[pdesc_mem[pid_reg]];
                            if (!waiting_reg[pid_reg]) begin
                                st_reg <= ST_ABSENT;
                            end else if (head_mem[pdesc_mem[pid_reg]] == pid_reg) begin
                                pout_reg <= pid_reg;
                                waiting_reg[pid_reg] <= 1'b0;
                                if (tail_mem[pdesc_mem[pid_reg]] == pid_reg) begin
                                    in_use_reg[pdesc_mem[pid_reg]] <= 1'b0;
                                    rel_reg <= 1'b1;
                                end else begin
                                    head_mem[pdesc_mem[pid_reg]] <= next_mem[pid_reg];
                                end
                            end
                        end
                    endcase
                end
                S_WALK: begin
                    // advance until the link to the process is found, then unlink
                    if (next_mem[q_reg] == pid_reg) begin
                        next_mem[q_reg] <= next_mem[pid_reg];
                        if (tail_mem[d_reg] == pid_reg) tail_mem[d_reg] <= q_reg;
                        waiting_reg[pid_reg] <= 1'b0;
                        pout_reg <= pid_reg;
                    end else begin
                        q_reg <= next_mem[q_reg];
                    end
                end
                S_OUT: mvalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/tb_semaphore_wait_queue_table.sv =====
// Testbench for the semaphore wait-queue table: random and directed commands checked against a predictor.
`timescale 1ns / 100ps

module tb_semaphore_wait_queue_table
    import swqt_pkg::*;
;

    localparam int NDESC = 32;

    typedef struct packed {
        logic [4:0]  proc_id;
        logic [31:0] sem_key;
        cmd_t        command;
    } table_cmd_t;

    typedef struct packed {
        logic       released;
        logic [4:0] proc_out;
        status_t    status;
    } table_resp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    semaphore_wait_queue_table #(.NUM_ENTRIES(NDESC)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Predictor copy of the table
    logic [31:0] pd_key    [NDESC];
    logic        pd_used   [NDESC];
    logic [4:0]  pd_head   [NDESC];
    logic [4:0]  pd_tail   [NDESC];
    logic [4:0]  pp_next   [NPROC];
    logic        pp_wait   [NPROC];
    logic [4:0]  pp_desc   [NPROC];

    table_cmd_t  cmd_queue[$];
    table_resp_t resp_expected[$];
    int          errors;
    logic        hold_send;

    logic [31:0] key_pool[8];

    function automatic int find_key(logic [31:0] key);
        for (int d = 0; d < NDESC; d++)
            if (pd_used[d] && pd_key[d] == key) return d;
        return -1;
    endfunction

    function automatic table_resp_t predict_table(table_cmd_t c);
        table_resp_t r;
        int          d;
        logic [4:0]  p;
        logic [4:0]  q;
        r = '{released: 1'b0, proc_out: 5'd0, status: ST_OK};
        p = c.proc_id;
        case (c.command)
            CMD_BLOCK: begin
                if (pp_wait[p]) begin
                    r.status = ST_ABSENT;
                end else begin
                    d = find_key(c.sem_key);
                    if (d < 0) begin
                        for (int k = NDESC - 1; k >= 0; k--)
                            if (!pd_used[k]) d = k;
                        if (d < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            pd_used[d] = 1'b1;
                            pd_key[d]  = c.sem_key;
                            pd_head[d] = p;
                            pd_tail[d] = p;
                        end
                    end else begin
                        pp_next[pd_tail[d]] = p;
                        pd_tail[d] = p;
                    end
                    if (r.status == ST_OK) begin
                        pp_next[p] = p;
                        pp_wait[p] = 1'b1;
                        pp_desc[p] = 5'(d);
                    end
                end
            end
            CMD_POP, CMD_PEEK: begin
                d = find_key(c.sem_key);
                if (d < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    r.proc_out = pd_head[d];
                    if (c.command == CMD_POP) begin
                        pp_wait[pd_head[d]] = 1'b0;
                        if (pd_head[d] == pd_tail[d]) begin
                            pd_used[d] = 1'b0;
                            r.released = 1'b1;
                        end else begin
                            pd_head[d] = pp_next[pd_head[d]];
                        end
                    end
                end
            end
            default: begin
                if (!pp_wait[p]) begin
                    r.status = ST_ABSENT;
                end else begin
                    d = pp_desc[p];
                    r.proc_out = p;
                    pp_wait[p] = 1'b0;
                    if (pd_head[d] == p) begin
                        if (pd_head[d] == pd_tail[d]) begin
                            pd_used[d] = 1'b0;
                            r.released = 1'b1;
                        end else begin
                            pd_head[d] = pp_next[p];
                        end
                    end else begin
                        q = pd_head[d];
                        for (int i = 0; i < NPROC; i++) begin
                            if (pp_next[q] == p) break;
                            q = pp_next[q];
                        end
                        pp_next[q] = pp_next[p];
                        if (pd_tail[d] == p) pd_tail[d] = q;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_cmd(cmd_t op, logic [31:0] key, logic [4:0] p);
        table_cmd_t c;
        c.command = op;
        c.sem_key = key;
        c.proc_id = p;
        cmd_queue.push_back(c);
    endfunction

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Driver
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
            // hold
        end else begin
            if (s_tvalid) begin
                resp_expected.push_back(predict_table(table_cmd_t'(s_tdata[38:0])));
            end
            if (send_gap > 0 || hold_send || cmd_queue.size() == 0) begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cmd_queue.pop_front()};
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // Monitor
    int          recv_gap;
    int          gap_draw;
    table_resp_t got;
    table_resp_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = table_resp_t'(m_tdata);
                if (resp_expected.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = resp_expected.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.proc_out !== want.proc_out) begin
                        $display("%0t: proc_out expected %0d actual %0d",
                                 $time, want.proc_out, got.proc_out);
                        errors++;
                    end
                    if (got.released !== want.released) begin
                        $display("%0t: released expected %0d actual %0d",
                                 $time, want.released, got.released);
                        errors++;
                    end
                end
                gap_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                m_tready <= (gap_draw == 0);
                recv_gap <= gap_draw;
            end else if (recv_gap > 0) begin
                m_tready <= (recv_gap == 1);
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        cmd_t op;
        errors    = 0;
        hold_send = 1'b0;
        aresetn   = 1'b0;
        for (int i = 0; i < NDESC; i++) pd_used[i] = 1'b0;
        for (int i = 0; i < NPROC; i++) pp_wait[i] = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;

        // Directed: absent keys, extremes, fill pool, duplicates
        add_cmd(CMD_POP, 32'h0, 5'd0);
        add_cmd(CMD_PEEK, 32'hFFFF_FFFF, 5'd0);
        add_cmd(CMD_REMOVE, 32'h0, 5'd31);
        add_cmd(CMD_BLOCK, 32'h0, 5'd0);
        add_cmd(CMD_BLOCK, 32'h0, 5'd0);
        add_cmd(CMD_BLOCK, 32'hFFFF_FFFF, 5'd31);
        add_cmd(CMD_BLOCK, 32'h0, 5'd1);
        add_cmd(CMD_BLOCK, 32'h0, 5'd2);
        add_cmd(CMD_PEEK, 32'h0, 5'd0);
        add_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 5'd1);
        add_cmd(CMD_REMOVE, 32'h0, 5'd2);
        add_cmd(CMD_POP, 32'h0, 5'd0);
        add_cmd(CMD_POP, 32'h0, 5'd0);
        add_cmd(CMD_REMOVE, 32'h0, 5'd31);
        // Fill every descriptor, one process each
        for (int i = 0; i < 32; i++) add_cmd(CMD_BLOCK, 32'hA000_0000 + i, 5'(i));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait out and drain the first batch, then send a remove for every process
        wait (cmd_queue.size() == 0);
        hold_send = 1'b1;
        @(posedge aclk);
        wait (resp_expected.size() == 0 && !s_tvalid);
        hold_send = 1'b0;
        for (int i = 0; i < 32; i++) add_cmd(CMD_REMOVE, 32'h5555_AAAA, 5'(i));

        // Random: mostly keys from a small pool so queues grow deep
        for (int n = 0; n < 1600; n++) begin
            op = cmd_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 4) op = CMD_BLOCK;
            add_cmd(op, ($urandom_range(0, 15) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)],
                    5'($urandom_range(0, 31)));
        end

        wait (cmd_queue.size() == 0);
        @(posedge aclk);
        wait (resp_expected.size() == 0 && !s_tvalid);
        repeat (200) @(posedge aclk);
        if (errors == 0 && resp_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
